FILE: rtl/core/block_stats_above_mean_filter_macros.svh
// assertion macros for the grouped mean filter block
// used by bsamf_seq and the top level; needs clk and rst_n in scope
`ifndef BLOCK_STATS_ABOVE_MEAN_FILTER_MACROS_SVH
`define BLOCK_STATS_ABOVE_MEAN_FILTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define BSAMF_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BSAMF_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bsamf_pkg.sv
// shared types and constants of the grouped mean filter block
// no dependencies; imported by every module of the block
package bsamf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_GROUP   = 32;
  localparam int CNT_W       = $clog2(MAX_GROUP + 1);
  localparam int ADDR_W      = $clog2(MAX_GROUP);
  localparam int SUM_W       = SAMPLE_BITS + ADDR_W;
  localparam int PROD_W      = SAMPLE_BITS + CNT_W;
  localparam int CFG_W       = 6;

  localparam logic [CFG_W-1:0] GROUP_SIZE_RST = CFG_W'(4);

  typedef enum logic [1:0] {
    KIND_MEMBER = 2'd0,
    KIND_MAX    = 2'd1,
    KIND_MIN    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TEST,
    ST_MEMBER,
    ST_MAX,
    ST_MIN
  } state_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   final_sample;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    kind_t                  result_kind;
    logic                   run_end;
  } out_item_t;

  // group store access from the sequencer
  typedef struct packed {
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
  } mem_req_t;

  // operands for the shared mean test unit
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
  } cmp_req_t;

  // result load into the output register
  typedef struct packed {
    logic      load;
    out_item_t item;
  } emit_t;

endpackage

FILE: rtl/core/bsamf_store.sv
// group store: one write port and one registered read port
// depends on bsamf_pkg
module bsamf_store (
  input  logic                            clk,
  input  bsamf_pkg::mem_req_t             req,
  output logic [bsamf_pkg::SAMPLE_BITS-1:0] rdata
);
  import bsamf_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [MAX_GROUP];
  logic [SAMPLE_BITS-1:0] rdata_r;

  // sample write
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/bsamf_cmp.sv
// shared mean test unit: value * count >= sum, result registered
// depends on bsamf_pkg
module bsamf_cmp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bsamf_pkg::cmp_req_t               req,
  input  logic [bsamf_pkg::SAMPLE_BITS-1:0] value,
  output logic                              pass,
  output logic [bsamf_pkg::SAMPLE_BITS-1:0] pass_value
);
  import bsamf_pkg::*;

  logic [PROD_W-1:0]      prod;
  logic                   pass_r;
  logic [SAMPLE_BITS-1:0] value_r;

  // exact integer test against the group sum
  assign prod = PROD_W'(value) * PROD_W'(req.count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b0;
    end else if (req.start) begin
      pass_r <= (prod >= PROD_W'(req.sum));
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      value_r <= value;
    end
  end

  assign pass       = pass_r;
  assign pass_value = value_r;

endmodule

FILE: rtl/core/bsamf_seq.sv
// sequencer: group accumulators, config register and replay control
// depends on bsamf_pkg and the assertion macro header
`include "block_stats_above_mean_filter_macros.svh"

module bsamf_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bsamf_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  input  bsamf_pkg::in_item_t               in_item,
  output logic                              in_stall,
  input  logic                              out_ready,
  input  logic                              cmp_pass,
  input  logic [bsamf_pkg::SAMPLE_BITS-1:0] cmp_value,
  output bsamf_pkg::mem_req_t               mem_req,
  output bsamf_pkg::cmp_req_t               cmp_req,
  output bsamf_pkg::emit_t                  emit
);
  import bsamf_pkg::*;

  state_t                 state_r, state_nxt;
  logic [CFG_W-1:0]       group_size_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;

  logic             accept;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] eff_size;
  logic             close;
  logic             last;

  // effective group size: zero acts as one, clipped to the store depth
  always_comb begin
    if (group_size_r == '0) begin
      eff_size = CNT_W'(1);
    end else if (CNT_W'(group_size_r) > CNT_W'(MAX_GROUP)) begin
      eff_size = CNT_W'(MAX_GROUP);
    end else begin
      eff_size = CNT_W'(group_size_r);
    end
  end

  assign accept    = (state_r == ST_IDLE) && in_valid;
  assign count_inc = count_r + CNT_W'(1);
  assign close     = (count_inc >= eff_size) || in_item.final_sample;
  assign last      = ((idx_r + CNT_W'(1)) == count_r);

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= GROUP_SIZE_RST;
    end else if (cfg_we) begin
      group_size_r <= cfg_wdata;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && close) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:   state_nxt = ST_TEST;
      ST_TEST:   state_nxt = ST_MEMBER;
      ST_MEMBER: begin
        if (!cmp_pass || out_ready) begin
          state_nxt = last ? ST_MAX : ST_READ;
        end
      end
      ST_MAX: begin
        if (out_ready) begin
          state_nxt = ST_MIN;
        end
      end
      ST_MIN: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall         = (state_r != ST_IDLE);
    mem_req.wr_en    = accept && (count_r < CNT_W'(MAX_GROUP));
    mem_req.wr_addr  = count_r[ADDR_W-1:0];
    mem_req.wr_data  = in_item.sample;
    mem_req.rd_en    = 1'b0;
    mem_req.rd_addr  = idx_r[ADDR_W-1:0];
    cmp_req.start    = 1'b0;
    cmp_req.count    = count_r;
    cmp_req.sum      = sum_r;
    emit.load        = 1'b0;
    emit.item.value  = cmp_value;
    emit.item.result_kind = KIND_MEMBER;
    emit.item.run_end     = 1'b0;
    case (state_r)
      ST_READ:   mem_req.rd_en = 1'b1;
      ST_TEST:   cmp_req.start = 1'b1;
      ST_MEMBER: emit.load = cmp_pass && out_ready;
      ST_MAX: begin
        emit.load             = out_ready;
        emit.item.value       = max_r;
        emit.item.result_kind = KIND_MAX;
      end
      ST_MIN: begin
        emit.load             = out_ready;
        emit.item.value       = min_r;
        emit.item.result_kind = KIND_MIN;
        emit.item.run_end     = 1'b1;
      end
      default: begin
        emit.load = 1'b0;
      end
    endcase
  end

  // group accumulators and replay index
  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    max_nxt   = max_r;
    min_nxt   = min_r;
    idx_nxt   = idx_r;
    if (accept) begin
      count_nxt = count_inc;
      sum_nxt   = sum_r + SUM_W'(in_item.sample);
      if (in_item.sample > max_r) begin
        max_nxt = in_item.sample;
      end
      if (in_item.sample < min_r) begin
        min_nxt = in_item.sample;
      end
      idx_nxt = '0;
    end
    if ((state_r == ST_MEMBER) && (!cmp_pass || out_ready) && !last) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
    if ((state_r == ST_MIN) && out_ready) begin
      count_nxt = '0;
      sum_nxt   = '0;
      max_nxt   = '0;
      min_nxt   = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      sum_r   <= '0;
      max_r   <= '0;
      min_r   <= '1;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      max_r   <= max_nxt;
      min_r   <= min_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // checks
  `BSAMF_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_GROUP), "count beyond store depth")
  `BSAMF_ASSERT_NOW(a_load_ready, emit.load, out_ready, "result loaded into a full register")
  `BSAMF_ASSERT_NOW(a_replay_order, state_r != ST_IDLE, (min_r <= max_r) && (idx_r < count_r), "replay with empty or inconsistent group")
  `BSAMF_ASSERT_NEXT(a_clear_after_min, (state_r == ST_MIN) && out_ready, (count_r == '0) && (sum_r == '0), "group not cleared after minimum")

endmodule

FILE: rtl/core/block_stats_above_mean_filter.sv
// Grouped statistics filter with mean threshold.
// Samples arrive on the in_ channel (in_valid / in_stall, item accepted when
// valid is high and stall low). Samples collect into groups of cfg group
// size (written through cfg_we / cfg_wdata, reset value 4, zero acts as one,
// above 32 acts as 32); a sample with final_sample set closes the group early.
// On close the block emits on the out_ channel every member at or above the
// group mean in arrival order (kind 0), then the maximum (kind 1), then the
// minimum (kind 2, run_end set).
// A sample that leaves the group open is taken without a stall. A closing
// sample keeps in_stall high while the group is replayed: each member is
// read from the group store, tested in the shared multiply and compare unit
// and then offered to the output register, followed by the maximum and then
// the minimum. The first result passes the store read register, the compare
// register and the output register.
// The output register holds a result until the receiver takes it; while it
// is full and out_stall is high, the replay waits before its next result and in_stall stays high.
// Synchronous reset (rst_n low) empties the group and the output register and
// restores the group size to 4.
// Depends on bsamf_pkg, bsamf_store, bsamf_cmp, bsamf_seq and the macro header.
`include "block_stats_above_mean_filter_macros.svh"

module block_stats_above_mean_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bsamf_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  input  bsamf_pkg::in_item_t         in_item,
  output logic                        in_stall,
  output logic                        out_valid,
  output bsamf_pkg::out_item_t        out_item,
  input  logic                        out_stall
);
  import bsamf_pkg::*;

  mem_req_t               mem_req;
  cmp_req_t               cmp_req;
  emit_t                  emit;
  logic [SAMPLE_BITS-1:0] rdata;
  logic                   cmp_pass;
  logic [SAMPLE_BITS-1:0] cmp_value;
  logic                   out_ready;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  bsamf_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  bsamf_cmp u_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (cmp_req),
    .value      (rdata),
    .pass       (cmp_pass),
    .pass_value (cmp_value)
  );

  bsamf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_ready (out_ready),
    .cmp_pass  (cmp_pass),
    .cmp_value (cmp_value),
    .mem_req   (mem_req),
    .cmp_req   (cmp_req),
    .emit      (emit)
  );

  // output register: free when empty or being taken this cycle
  assign out_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= emit.load;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_item_r <= emit.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  `BSAMF_ASSERT_NOW(a_run_end_kind, out_valid_r && out_item_r.run_end, out_item_r.result_kind == KIND_MIN, "run end on a result other than the minimum")
  `BSAMF_ASSERT_NOW(a_stall_on_result, out_valid_r && (out_item_r.result_kind != KIND_MIN), in_stall, "input taken before group results finished")

endmodule
